// ===== rtl/fcbm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcbm_pkg
// Shared types and constants of the block allocation table manager.
// ----------------------------------------------------------------------------
package fcbm_pkg;

    localparam int KEY_W = 64;
    localparam int BN_W  = 8;

    localparam logic [8:0] DISK_BLOCKS_RST = 9'd256;
    localparam logic [6:0] RESERVED_RST    = 7'd13;

    typedef enum logic [0:0] {
        REG_DISK_BLOCKS     = 1'b0,
        REG_RESERVED_BLOCKS = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ACT_FORMAT = 3'd0,
        ACT_CREATE = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_APPEND = 3'd3,
        ACT_UNLINK = 3'd4,
        ACT_NEXT   = 3'd5,
        ACT_FIRST  = 3'd6,
        ACT_NOP    = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EXISTS     = 3'd1,
        ST_DIR_FULL   = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_HAS_DATA   = 3'd4,
        ST_DISK_FULL  = 3'd5,
        ST_NO_BLOCKS  = 3'd6,
        ST_NOT_MEMBER = 3'd7
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_FMT,
        S_SRCH,
        S_DECIDE,
        S_APP_HEAD,
        S_APP_RDA,
        S_APP_CLR,
        S_WSTART,
        S_WALK,
        S_APP_LINK,
        S_UL_RDBN,
        S_UL_FIX,
        S_UL_HEAD,
        S_UL_PUSH,
        S_NX_RDBN,
        S_NX_VAL,
        S_DONE
    } ctl_state_t;

    // table read address source
    typedef enum logic [1:0] {
        RD_ZERO,
        RD_BN,
        RD_FIRST,
        RD_VAL
    } rd_sel_t;

    // table write address source
    typedef enum logic [2:0] {
        WA_ZERO,
        WA_A,
        WA_B,
        WA_BN,
        WA_SWEEP
    } wa_sel_t;

    // table write data source
    typedef enum logic [2:0] {
        WD_ZERO,
        WD_VAL,
        WD_A,
        WD_BN,
        WD_SWEEP
    } wd_sel_t;

    // result value source
    typedef enum logic [1:0] {
        VS_ZERO,
        VS_A,
        VS_FIRST,
        VS_VAL
    } vs_sel_t;

    typedef struct packed {
        logic    load_req;
        logic    srch_clr;
        logic    srch_step;
        rd_sel_t rd_sel;
        logic    wr_en;
        wa_sel_t wa_sel;
        wd_sel_t wd_sel;
        logic    walk_init;
        logic    walk_step;
        logic    hold_a;
        logic    dir_create;
        logic    dir_remove;
        logic    dir_first_a;
        logic    dir_first_val;
        logic    dir_clear;
        logic    sweep_clr;
        logic    sweep_step;
        logic    res_set;
        status_t res_st;
        vs_sel_t res_vs;
        logic    out_push;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    found;
        logic    free_found;
        logic    first_zero;
        logic    first_eq_bn;
        logic    val_zero;
        logic    walk_hit;
        logic    walk_last;
        logic    srch_last;
        logic    sweep_last;
        logic    out_free;
    } sts_t;

endpackage
`default_nettype wire

// ===== rtl/fcbm_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcbm_datapath
// Allocation table memory, directory slots, walk and sweep counters and the
// result register.
// ----------------------------------------------------------------------------
module fcbm_datapath #(
    parameter int NUM_BLOCKS = 256,
    parameter int DIR_SLOTS  = 16,
    parameter int NAME_BITS  = 64
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  fcbm_pkg::cmd_t              cmd,
    output fcbm_pkg::sts_t              sts,
    input  wire [2:0]                   in_action,
    input  wire [fcbm_pkg::KEY_W-1:0]   in_key,
    input  wire [fcbm_pkg::BN_W-1:0]    in_bn,
    input  wire [8:0]                   disk_blocks,
    input  wire [6:0]                   reserved_blocks,
    output logic                        m_valid,
    input  wire                         m_ready,
    output logic [2:0]                  m_status,
    output logic [fcbm_pkg::BN_W-1:0]   m_value
);

    localparam int AW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int SW  = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;
    localparam int SWW = $clog2(SW);
    localparam int SLW = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;

    function automatic logic in_rng(input logic [7:0] b);
        return 32'(b) < NUM_BLOCKS;
    endfunction

    function automatic logic [AW-1:0] to_addr(input logic [7:0] b);
        logic [AW+7:0] ext;
        ext = {AW'(0), b};
        return ext[AW-1:0];
    endfunction

    fcbm_pkg::action_t    act_reg;
    logic [NAME_BITS-1:0] key_reg;
    logic [7:0]           bn_reg;
    logic [SLW-1:0]       cnt_reg;
    logic                 found_reg;
    logic [SLW-1:0]       slot_reg;
    logic                 free_found_reg;
    logic [SLW-1:0]       free_slot_reg;
    logic [7:0]           b_reg;
    logic [AW-1:0]        n_reg;
    logic [7:0]           a_reg;
    logic [SWW-1:0]       sweep_reg;
    logic [7:0]           rdata_reg;
    logic                 rd_oob_reg;
    logic [2:0]           res_st_reg;
    logic [7:0]           res_val_reg;
    logic                 m_valid_reg;
    logic [2:0]           m_st_reg;
    logic [7:0]           m_val_reg;

    logic [7:0]           mem [NUM_BLOCKS];
    logic                 dir_valid_reg [DIR_SLOTS];
    logic [NAME_BITS-1:0] dir_name_reg [DIR_SLOTS];
    logic [7:0]           dir_first_reg [DIR_SLOTS];

    logic [7:0]    rdval;
    logic [7:0]    first_val;
    logic [7:0]    raddr8;
    logic [7:0]    waddr8;
    logic [AW-1:0] waddr;
    logic          wr_ok;
    logic [7:0]    wdata;
    logic [7:0]    sweep_val;
    logic [8:0]    eff9;
    logic [7:0]    r1;
    logic [8:0]    i9;
    logic [7:0]    res_val;

    assign rdval     = rd_oob_reg ? 8'd0 : rdata_reg;
    assign first_val = dir_first_reg[slot_reg];

    // format image of one table entry
    always_comb begin
        eff9 = (32'(disk_blocks) > SW) ? 9'(SW) : disk_blocks;
        r1   = {1'b0, reserved_blocks} + 8'd1;
        i9   = 9'(sweep_reg);
        if ({1'b0, r1} >= eff9) begin
            sweep_val = 8'd0;
        end else if (i9 == 9'd0) begin
            sweep_val = r1;
        end else if (i9 <= {2'b0, reserved_blocks}) begin
            sweep_val = 8'd0;
        end else if ((i9 + 9'd1) < eff9) begin
            sweep_val = 8'(i9 + 9'd1);
        end else begin
            sweep_val = 8'd0;
        end
    end

    always_comb begin
        unique case (cmd.rd_sel)
            fcbm_pkg::RD_ZERO:  raddr8 = 8'd0;
            fcbm_pkg::RD_BN:    raddr8 = bn_reg;
            fcbm_pkg::RD_FIRST: raddr8 = first_val;
            fcbm_pkg::RD_VAL:   raddr8 = rdval;
            default:            raddr8 = 8'd0;
        endcase
    end

    always_comb begin
        unique case (cmd.wa_sel)
            fcbm_pkg::WA_A:  waddr8 = a_reg;
            fcbm_pkg::WA_B:  waddr8 = b_reg;
            fcbm_pkg::WA_BN: waddr8 = bn_reg;
            default:         waddr8 = 8'd0;
        endcase
        if (cmd.wa_sel == fcbm_pkg::WA_SWEEP) begin
            waddr = AW'(sweep_reg);
            wr_ok = cmd.wr_en;
        end else begin
            waddr = to_addr(waddr8);
            wr_ok = cmd.wr_en && in_rng(waddr8);
        end
        unique case (cmd.wd_sel)
            fcbm_pkg::WD_VAL:   wdata = rdval;
            fcbm_pkg::WD_A:     wdata = a_reg;
            fcbm_pkg::WD_BN:    wdata = bn_reg;
            fcbm_pkg::WD_SWEEP: wdata = sweep_val;
            default:            wdata = 8'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[waddr] <= wdata;
        end
        rdata_reg  <= mem[to_addr(raddr8)];
        rd_oob_reg <= !in_rng(raddr8);
    end

    // request capture, slot search, walk and sweep counters
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            act_reg <= fcbm_pkg::action_t'(in_action);
            key_reg <= in_key[NAME_BITS-1:0];
            bn_reg  <= in_bn;
        end
        if (cmd.srch_clr) begin
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (cmd.srch_step) begin
            cnt_reg <= cnt_reg + SLW'(1);
            if (dir_valid_reg[cnt_reg] && dir_name_reg[cnt_reg] == key_reg && !found_reg) begin
                found_reg <= 1'b1;
                slot_reg  <= cnt_reg;
            end
            if (!dir_valid_reg[cnt_reg] && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_slot_reg  <= cnt_reg;
            end
        end
        if (cmd.walk_init) begin
            b_reg <= first_val;
            n_reg <= '0;
        end else if (cmd.walk_step) begin
            b_reg <= rdval;
            n_reg <= n_reg + AW'(1);
        end
        if (cmd.hold_a) begin
            a_reg <= rdval;
        end
        if (cmd.sweep_clr) begin
            sweep_reg <= '0;
        end else if (cmd.sweep_step) begin
            sweep_reg <= sweep_reg + SWW'(1);
        end
        if (cmd.res_set) begin
            res_st_reg  <= cmd.res_st;
            res_val_reg <= res_val;
        end
    end

    always_comb begin
        unique case (cmd.res_vs)
            fcbm_pkg::VS_A:     res_val = a_reg;
            fcbm_pkg::VS_FIRST: res_val = first_val;
            fcbm_pkg::VS_VAL:   res_val = rdval;
            default:            res_val = 8'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIR_SLOTS; k++) begin
                dir_valid_reg[k] <= 1'b0;
            end
        end else if (cmd.dir_clear) begin
            for (int k = 0; k < DIR_SLOTS; k++) begin
                dir_valid_reg[k] <= 1'b0;
            end
        end else if (cmd.dir_create) begin
            dir_valid_reg[free_slot_reg] <= 1'b1;
        end else if (cmd.dir_remove) begin
            dir_valid_reg[slot_reg] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.dir_create) begin
            dir_name_reg[free_slot_reg]  <= key_reg;
            dir_first_reg[free_slot_reg] <= 8'd0;
        end else if (cmd.dir_first_a) begin
            dir_first_reg[slot_reg] <= a_reg;
        end else if (cmd.dir_first_val) begin
            dir_first_reg[slot_reg] <= rdval;
        end
    end

    // result register towards the output channel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_push) begin
            m_st_reg  <= res_st_reg;
            m_val_reg <= res_val_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_st_reg;
    assign m_value  = m_val_reg;

    assign sts.action      = act_reg;
    assign sts.found       = found_reg;
    assign sts.free_found  = free_found_reg;
    assign sts.first_zero  = (first_val == 8'd0);
    assign sts.first_eq_bn = (first_val == bn_reg);
    assign sts.val_zero    = (rdval == 8'd0);
    assign sts.walk_hit    = (bn_reg != 8'd0) && (rdval == bn_reg);
    assign sts.walk_last   = (n_reg == AW'(NUM_BLOCKS - 1));
    assign sts.srch_last   = (cnt_reg == SLW'(DIR_SLOTS - 1));
    assign sts.sweep_last  = (sweep_reg == SWW'(SW - 1));
    assign sts.out_free    = !m_valid_reg || m_ready;

endmodule
`default_nettype wire

// ===== rtl/fcbm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcbm_ctrl
// Request sequencer: slot search, table walks, relinking and result hand-off.
// ----------------------------------------------------------------------------
module fcbm_ctrl (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  fcbm_pkg::sts_t   sts,
    output fcbm_pkg::cmd_t   cmd
);

    fcbm_pkg::ctl_state_t state_reg;
    fcbm_pkg::ctl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fcbm_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            fcbm_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = fcbm_pkg::S_DISPATCH;
                end
            end
            fcbm_pkg::S_DISPATCH: begin
                priority if (sts.action == fcbm_pkg::ACT_FORMAT) begin
                    cmd.dir_clear = 1'b1;
                    cmd.sweep_clr = 1'b1;
                    state_next    = fcbm_pkg::S_FMT;
                end else if (sts.action == fcbm_pkg::ACT_NOP) begin
                    cmd.res_set = 1'b1;
                    cmd.res_st  = fcbm_pkg::ST_OK;
                    state_next  = fcbm_pkg::S_DONE;
                end else begin
                    cmd.srch_clr = 1'b1;
                    state_next   = fcbm_pkg::S_SRCH;
                end
            end
            fcbm_pkg::S_FMT: begin
                cmd.wr_en      = 1'b1;
                cmd.wa_sel     = fcbm_pkg::WA_SWEEP;
                cmd.wd_sel     = fcbm_pkg::WD_SWEEP;
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last) begin
                    cmd.res_set = 1'b1;
                    cmd.res_st  = fcbm_pkg::ST_OK;
                    state_next  = fcbm_pkg::S_DONE;
                end
            end
            fcbm_pkg::S_SRCH: begin
                cmd.srch_step = 1'b1;
                if (sts.srch_last) begin
                    state_next = fcbm_pkg::S_DECIDE;
                end
            end
            fcbm_pkg::S_DECIDE: begin
                cmd.res_st = fcbm_pkg::ST_OK;
                unique case (sts.action)
                    fcbm_pkg::ACT_CREATE: begin
                        cmd.res_set = 1'b1;
                        state_next  = fcbm_pkg::S_DONE;
                        priority if (sts.found) begin
                            cmd.res_st = fcbm_pkg::ST_EXISTS;
                        end else if (sts.free_found) begin
                            cmd.dir_create = 1'b1;
                        end else begin
                            cmd.res_st = fcbm_pkg::ST_DIR_FULL;
                        end
                    end
                    fcbm_pkg::ACT_REMOVE: begin
                        cmd.res_set = 1'b1;
                        state_next  = fcbm_pkg::S_DONE;
                        priority if (!sts.found) begin
                            cmd.res_st = fcbm_pkg::ST_NOT_FOUND;
                        end else if (!sts.first_zero) begin
                            cmd.res_st = fcbm_pkg::ST_HAS_DATA;
                        end else begin
                            cmd.dir_remove = 1'b1;
                        end
                    end
                    fcbm_pkg::ACT_FIRST: begin
                        cmd.res_set = 1'b1;
                        state_next  = fcbm_pkg::S_DONE;
                        if (!sts.found) begin
                            cmd.res_st = fcbm_pkg::ST_NOT_FOUND;
                        end else begin
                            cmd.res_vs = fcbm_pkg::VS_FIRST;
                        end
                    end
                    fcbm_pkg::ACT_APPEND: begin
                        cmd.rd_sel = fcbm_pkg::RD_ZERO;
                        state_next = fcbm_pkg::S_APP_HEAD;
                    end
                    fcbm_pkg::ACT_UNLINK, fcbm_pkg::ACT_NEXT: begin
                        priority if (!sts.found) begin
                            cmd.res_set = 1'b1;
                            cmd.res_st  = fcbm_pkg::ST_NOT_FOUND;
                            state_next  = fcbm_pkg::S_DONE;
                        end else if (sts.first_zero) begin
                            cmd.res_set = 1'b1;
                            cmd.res_st  = fcbm_pkg::ST_NO_BLOCKS;
                            state_next  = fcbm_pkg::S_DONE;
                        end else if (sts.first_eq_bn) begin
                            state_next = (sts.action == fcbm_pkg::ACT_UNLINK) ?
                                         fcbm_pkg::S_UL_RDBN : fcbm_pkg::S_NX_RDBN;
                        end else begin
                            state_next = fcbm_pkg::S_WSTART;
                        end
                    end
                    default: begin
                        cmd.res_set = 1'b1;
                        state_next  = fcbm_pkg::S_DONE;
                    end
                endcase
            end
            fcbm_pkg::S_APP_HEAD: begin
                // disk full takes precedence over an unknown key
                priority if (sts.val_zero) begin
                    cmd.res_set = 1'b1;
                    cmd.res_st  = fcbm_pkg::ST_DISK_FULL;
                    state_next  = fcbm_pkg::S_DONE;
                end else if (!sts.found) begin
                    cmd.res_set = 1'b1;
                    cmd.res_st  = fcbm_pkg::ST_NOT_FOUND;
                    state_next  = fcbm_pkg::S_DONE;
                end else begin
                    cmd.hold_a = 1'b1;
                    cmd.rd_sel = fcbm_pkg::RD_VAL;
                    state_next = fcbm_pkg::S_APP_RDA;
                end
            end
            fcbm_pkg::S_APP_RDA: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = fcbm_pkg::WA_ZERO;
                cmd.wd_sel = fcbm_pkg::WD_VAL;
                state_next = fcbm_pkg::S_APP_CLR;
            end
            fcbm_pkg::S_APP_CLR: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = fcbm_pkg::WA_A;
                cmd.wd_sel = fcbm_pkg::WD_ZERO;
                if (sts.first_zero) begin
                    cmd.dir_first_a = 1'b1;
                    cmd.res_set     = 1'b1;
                    cmd.res_st      = fcbm_pkg::ST_OK;
                    cmd.res_vs      = fcbm_pkg::VS_A;
                    state_next      = fcbm_pkg::S_DONE;
                end else begin
                    state_next = fcbm_pkg::S_WSTART;
                end
            end
            fcbm_pkg::S_WSTART: begin
                cmd.walk_init = 1'b1;
                cmd.rd_sel    = fcbm_pkg::RD_FIRST;
                state_next    = fcbm_pkg::S_WALK;
            end
            fcbm_pkg::S_WALK: begin
                cmd.rd_sel = fcbm_pkg::RD_VAL;
                if (sts.action == fcbm_pkg::ACT_APPEND) begin
                    priority if (sts.val_zero) begin
                        state_next = fcbm_pkg::S_APP_LINK;
                    end else if (sts.walk_last) begin
                        // step bound reached: link after the last block visited
                        cmd.walk_step = 1'b1;
                        state_next    = fcbm_pkg::S_APP_LINK;
                    end else begin
                        cmd.walk_step = 1'b1;
                    end
                end else begin
                    priority if (sts.walk_hit) begin
                        state_next = (sts.action == fcbm_pkg::ACT_UNLINK) ?
                                     fcbm_pkg::S_UL_RDBN : fcbm_pkg::S_NX_RDBN;
                    end else if (sts.val_zero || sts.walk_last) begin
                        cmd.res_set = 1'b1;
                        cmd.res_st  = fcbm_pkg::ST_NOT_MEMBER;
                        state_next  = fcbm_pkg::S_DONE;
                    end else begin
                        cmd.walk_step = 1'b1;
                    end
                end
            end
            fcbm_pkg::S_APP_LINK: begin
                cmd.wr_en   = 1'b1;
                cmd.wa_sel  = fcbm_pkg::WA_B;
                cmd.wd_sel  = fcbm_pkg::WD_A;
                cmd.res_set = 1'b1;
                cmd.res_st  = fcbm_pkg::ST_OK;
                cmd.res_vs  = fcbm_pkg::VS_A;
                state_next  = fcbm_pkg::S_DONE;
            end
            fcbm_pkg::S_UL_RDBN: begin
                cmd.rd_sel = fcbm_pkg::RD_BN;
                state_next = fcbm_pkg::S_UL_FIX;
            end
            fcbm_pkg::S_UL_FIX: begin
                if (sts.first_eq_bn) begin
                    cmd.dir_first_val = 1'b1;
                end else begin
                    cmd.wr_en  = 1'b1;
                    cmd.wa_sel = fcbm_pkg::WA_B;
                    cmd.wd_sel = fcbm_pkg::WD_VAL;
                end
                cmd.rd_sel = fcbm_pkg::RD_ZERO;
                state_next = fcbm_pkg::S_UL_HEAD;
            end
            fcbm_pkg::S_UL_HEAD: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = fcbm_pkg::WA_BN;
                cmd.wd_sel = fcbm_pkg::WD_VAL;
                state_next = fcbm_pkg::S_UL_PUSH;
            end
            fcbm_pkg::S_UL_PUSH: begin
                cmd.wr_en   = 1'b1;
                cmd.wa_sel  = fcbm_pkg::WA_ZERO;
                cmd.wd_sel  = fcbm_pkg::WD_BN;
                cmd.res_set = 1'b1;
                cmd.res_st  = fcbm_pkg::ST_OK;
                state_next  = fcbm_pkg::S_DONE;
            end
            fcbm_pkg::S_NX_RDBN: begin
                cmd.rd_sel = fcbm_pkg::RD_BN;
                state_next = fcbm_pkg::S_NX_VAL;
            end
            fcbm_pkg::S_NX_VAL: begin
                cmd.res_set = 1'b1;
                cmd.res_st  = fcbm_pkg::ST_OK;
                cmd.res_vs  = fcbm_pkg::VS_VAL;
                state_next  = fcbm_pkg::S_DONE;
            end
            fcbm_pkg::S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_push = 1'b1;
                    state_next   = fcbm_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = fcbm_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/fat_chain_block_manager_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fat_chain_block_manager_unit
// Block allocation table with a free list and a small file directory.
// ----------------------------------------------------------------------------
// A request on the s_ channel carries an action, a file key and a block number;
// every request gives exactly one result (status, block value) on the m_
// channel. One request is handled at a time. Each request except format and the
// unused action code first scans the directory, one slot per cycle; format
// sweeps min(NUM_BLOCKS,256) table entries, one entry per cycle. Append, unlink
// and next then walk the block chain through the single table read port, one
// link per cycle, up to NUM_BLOCKS links. s_tready rises with m_tvalid. The
// next request is taken while a result still waits in the output register; a
// stalled receiver only holds back the hand-off of the following result. Reset
// clears the directory and the sequencer and sets disk_blocks to 256 and
// reserved_blocks to 13; the table holds nothing until a format request is
// issued. Registers sit on the APB port at byte addresses 0 and 4 and take
// effect at the next format.
// ----------------------------------------------------------------------------
module fat_chain_block_manager_unit #(
    parameter int NUM_BLOCKS = 256,
    parameter int DIR_SLOTS  = 16,
    parameter int NAME_BITS  = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [71:0]  s_tdata,   // file_key[63:0], block_number[71:64]
    input  wire [2:0]   s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // block_value[7:0]
    output logic [2:0]  m_tuser,   // status[2:0]
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [8:0]     disk_blocks_reg;
    logic [6:0]     reserved_reg;
    fcbm_pkg::cmd_t cmd;
    fcbm_pkg::sts_t sts;
    logic           cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disk_blocks_reg <= fcbm_pkg::DISK_BLOCKS_RST;
            reserved_reg    <= fcbm_pkg::RESERVED_RST;
        end else if (cfg_wr) begin
            unique case (fcbm_pkg::reg_idx_t'(paddr[2]))
                fcbm_pkg::REG_DISK_BLOCKS:     disk_blocks_reg <= pwdata[8:0];
                fcbm_pkg::REG_RESERVED_BLOCKS: reserved_reg    <= pwdata[6:0];
                default:                       disk_blocks_reg <= disk_blocks_reg;
            endcase
        end
    end

    always_comb begin
        unique case (fcbm_pkg::reg_idx_t'(paddr[2]))
            fcbm_pkg::REG_DISK_BLOCKS:     prdata = {23'd0, disk_blocks_reg};
            fcbm_pkg::REG_RESERVED_BLOCKS: prdata = {25'd0, reserved_reg};
            default:                       prdata = 32'd0;
        endcase
    end

    fcbm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    fcbm_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .DIR_SLOTS  (DIR_SLOTS),
        .NAME_BITS  (NAME_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .in_action       (s_tuser),
        .in_key          (s_tdata[63:0]),
        .in_bn           (s_tdata[71:64]),
        .disk_blocks     (disk_blocks_reg),
        .reserved_blocks (reserved_reg),
        .m_valid         (m_tvalid),
        .m_ready         (m_tready),
        .m_status        (m_tuser),
        .m_value         (m_tdata)
    );

`ifndef SYNTHESIS
    a_rst_no_result : assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_one_at_a_time : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in progress");

    a_fail_zero_value : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != fcbm_pkg::ST_OK |-> m_tdata == 8'd0)
        else $error("failed request carries a block value");

    a_push_when_free : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_push |-> !m_tvalid || m_tready)
        else $error("result register overwritten");
`endif

endmodule
`default_nettype wire
